// ----- hdl/qlm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_pkg
// Shared widths, defaults and the CORDIC angle table for the quaternion
// logarithm pipeline.
// ----------------------------------------------------------------------------
package qlm_pkg;

    localparam int IN_W      = 18;
    localparam int OUT_W     = 20;
    localparam int SQ_W      = 2 * IN_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int GUARD     = 12;
    localparam int CW        = 34;
    localparam int TABLE_LEN = 24;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint ATAN_Q30 [0:TABLE_LEN-1] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    // Round a Q30 angle half up to frac fraction bits
    function automatic longint q30_to_frac(longint t, int frac);
        longint half;
        half = 64'sd1 <<< (29 - frac);
        return (t + half) >>> (30 - frac);
    endfunction

    function automatic longint atan_frac(int idx, int frac);
        return q30_to_frac(ATAN_Q30[idx], frac);
    endfunction

endpackage

// ----- hdl/quaternion_log_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_log_map
// Rotation vector (log map) of a fixed-point quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// One quaternion enters per clock while the output is not held, and its
// rotation vector leaves through an input, a squaring and a summing
// register, 18 stages of restoring square root, one set-up stage and
// CORDIC_STEPS stages of vectoring CORDIC, a multiply and a rounding stage,
// FRAC_BITS + 4 stages of restoring division (three lanes in parallel) and
// an output register. The whole pipe advances together and holds when a
// result waits at the output; an all-zero input gives a zero vector with
// zero_input set.
module quaternion_log_map
    import qlm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  quat_w,
    input  logic signed [IN_W-1:0]  quat_x,
    input  logic signed [IN_W-1:0]  quat_y,
    input  logic signed [IN_W-1:0]  quat_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] rot_x,
    output logic signed [OUT_W-1:0] rot_y,
    output logic signed [OUT_W-1:0] rot_z,
    output logic                    zero_input
);

    localparam int ANG_W  = FRAC_BITS + 4;
    localparam int PROD_W = ANG_W + IN_W;
    localparam int QW     = ANG_W;
    localparam int DW     = QW + ROOT_W + 1;
    localparam int RT_W   = SQ_W + 2;
    localparam int LAT    = 7 + ROOT_W + CORDIC_STEPS + QW;

    localparam logic signed [ANG_W-1:0] HALF_PI =
        ANG_W'(q30_to_frac(HALF_PI_Q30, FRAC_BITS));
    localparam logic [QW-1:0] POS_LIM = QW'((64'sd1 <<< (OUT_W - 1)) - 1);

    typedef struct packed {
        logic signed [IN_W-1:0] w;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
        logic                   zero;
    } carry_t;

    typedef struct packed {
        logic [ROOT_W-1:0] n;
        logic [2:0]        neg;
        logic              zero;
    } post_t;

    logic en;
    logic vld_reg [0:LAT-1];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- input, squares, sum ----------------
    carry_t          in_reg, sq_c_reg, sum_c_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg.w    <= quat_w;
            in_reg.x    <= quat_x;
            in_reg.y    <= quat_y;
            in_reg.z    <= quat_z;
            in_reg.zero <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0)
                           && (quat_z == '0);
            sqx_reg     <= SQ_W'(in_reg.x * in_reg.x);
            sqy_reg     <= SQ_W'(in_reg.y * in_reg.y);
            sqz_reg     <= SQ_W'(in_reg.z * in_reg.z);
            sq_c_reg    <= in_reg;
            sum_reg     <= sqx_reg + sqy_reg + sqz_reg;
            sum_c_reg   <= sq_c_reg;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [SQ_W-1:0]   rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    carry_t            sr_c_reg [0:ROOT_W];

    assign rem_reg[0]  = sum_reg;
    assign root_reg[0] = '0;
    assign sr_c_reg[0] = sum_c_reg;

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_sqrt
        localparam int I = ROOT_W - 1 - s;
        logic [RT_W-1:0] trial;
        assign trial = (RT_W'(root_reg[s]) << (I + 1)) + (RT_W'(1) << (2 * I));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (RT_W'(rem_reg[s]) >= trial)
                begin
                    rem_reg[s+1]  <= rem_reg[s] - SQ_W'(trial);
                    root_reg[s+1] <= root_reg[s] | (ROOT_W'(1) << I);
                end
                else
                begin
                    rem_reg[s+1]  <= rem_reg[s];
                    root_reg[s+1] <= root_reg[s];
                end
                sr_c_reg[s+1] <= sr_c_reg[s];
            end
        end
    end

    // ---------------- CORDIC set-up and stages ----------------
    logic signed [CW-1:0]    cx_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0]    cy_reg [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] ca_reg [0:CORDIC_STEPS];
    logic [ROOT_W-1:0]       cn_reg [0:CORDIC_STEPS];
    carry_t                  cc_reg [0:CORDIC_STEPS];

    logic signed [CW-1:0] w_ext, n_ext;
    assign w_ext = CW'(sr_c_reg[ROOT_W].w) <<< GUARD;
    assign n_ext = $signed(CW'(root_reg[ROOT_W])) <<< GUARD;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // turn a negative scalar part by -pi/2 first
            if (sr_c_reg[ROOT_W].w < 0)
            begin
                cx_reg[0] <= n_ext;
                cy_reg[0] <= -w_ext;
                ca_reg[0] <= HALF_PI;
            end
            else
            begin
                cx_reg[0] <= w_ext;
                cy_reg[0] <= n_ext;
                ca_reg[0] <= '0;
            end
            cn_reg[0] <= root_reg[ROOT_W];
            cc_reg[0] <= sr_c_reg[ROOT_W];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        localparam logic signed [ANG_W-1:0] DA = ANG_W'(atan_frac(k, FRAC_BITS));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[k] > 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    ca_reg[k+1] <= ca_reg[k] + DA;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    ca_reg[k+1] <= ca_reg[k] - DA;
                end
                cn_reg[k+1] <= cn_reg[k];
                cc_reg[k+1] <= cc_reg[k];
            end
        end
    end

    // ---------------- angle times component, rounding offset ----------------
    logic signed [ANG_W-1:0]  ang2;
    logic signed [PROD_W-1:0] prod_reg [0:2];
    post_t                    mp_reg, ab_reg;
    logic [DW-1:0]            num_reg [0:2];

    assign ang2 = ca_reg[CORDIC_STEPS] <<< 1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= PROD_W'(ang2) * PROD_W'(cc_reg[CORDIC_STEPS].x);
            prod_reg[1] <= PROD_W'(ang2) * PROD_W'(cc_reg[CORDIC_STEPS].y);
            prod_reg[2] <= PROD_W'(ang2) * PROD_W'(cc_reg[CORDIC_STEPS].z);
            mp_reg.n    <= cn_reg[CORDIC_STEPS];
            mp_reg.neg  <= '0;
            mp_reg.zero <= cc_reg[CORDIC_STEPS].zero;
            for (int j = 0; j < 3; j++)
            begin
                num_reg[j]   <= DW'(unsigned'(prod_reg[j] < 0 ? -prod_reg[j] : prod_reg[j]))
                                + DW'(mp_reg.n >> 1);
                ab_reg.neg[j] <= prod_reg[j] < 0;
            end
            ab_reg.n    <= mp_reg.n;
            ab_reg.zero <= mp_reg.zero;
        end
    end

    // ---------------- division, one quotient bit per stage ----------------
    logic [DW-1:0] dr_reg [0:QW][0:2];
    logic [QW-1:0] dq_reg [0:QW][0:2];
    post_t         dp_reg [0:QW];

    for (genvar j = 0; j < 3; j++)
    begin : g_lane0
        assign dr_reg[0][j] = num_reg[j];
        assign dq_reg[0][j] = '0;
    end
    assign dp_reg[0] = ab_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int I = QW - 1 - s;
        logic [DW-1:0] dv;
        assign dv = DW'(dp_reg[s].n) << I;
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (dr_reg[s][j] >= dv)
                    begin
                        dr_reg[s+1][j] <= dr_reg[s][j] - dv;
                        dq_reg[s+1][j] <= dq_reg[s][j] | (QW'(1) << I);
                    end
                    else
                    begin
                        dr_reg[s+1][j] <= dr_reg[s][j];
                        dq_reg[s+1][j] <= dq_reg[s][j];
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                dp_reg[s+1] <= dp_reg[s];
        end
    end

    // ---------------- sign, saturation, output register ----------------
    logic signed [OUT_W-1:0] res_next [0:2];
    logic signed [OUT_W-1:0] res_reg  [0:2];
    logic                    zero_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (dp_reg[QW].n == '0)
                res_next[j] = '0;
            else if (dp_reg[QW].neg[j])
                res_next[j] = (dq_reg[QW][j] > POS_LIM) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                         : -OUT_W'(dq_reg[QW][j]);
            else
                res_next[j] = (dq_reg[QW][j] > POS_LIM) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                         : OUT_W'(dq_reg[QW][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                res_reg[j] <= res_next[j];
            zero_reg <= dp_reg[QW].zero;
        end
    end

    assign out_valid  = vld_reg[LAT-1];
    assign rot_x      = res_reg[0];
    assign rot_y      = res_reg[1];
    assign rot_z      = res_reg[2];
    assign zero_input = zero_reg;

endmodule

// ----- hdl/qlm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_props
// Port-level checks for the quaternion logarithm pipeline.
// ----------------------------------------------------------------------------
module qlm_props
    import qlm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] rot_x,
    input logic signed [OUT_W-1:0] rot_y,
    input logic signed [OUT_W-1:0] rot_z,
    input logic                    zero_input
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z))
        else $error("result changed while stalled");

    // an empty output never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty output");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_input |-> rot_x == '0 && rot_y == '0 && rot_z == '0)
        else $error("zero quaternion gave non-zero vector");

endmodule

bind quaternion_log_map qlm_props u_qlm_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rot_x      (rot_x),
    .rot_y      (rot_y),
    .rot_z      (rot_z),
    .zero_input (zero_input)
);
